FILE: rtl/bottom_up_segment_tree_sum_macros.svh
// Assertion macros for the segment tree block.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef BOTTOM_UP_SEGMENT_TREE_SUM_MACROS_SVH
`define BOTTOM_UP_SEGMENT_TREE_SUM_MACROS_SVH

// Clocked property, switched off while reset is held.
`define BUST_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be seen at a clock edge.
`define BUST_NEVER(label, cond, msg) \
	`BUST_ASSERT(label, !(cond), msg)

`endif

FILE: rtl/bust_pkg.sv
// Shared types and constants for the segment tree block.
// No dependencies; imported by every module of the block.
package bust_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 10;
	localparam int END_W  = 11;
	localparam int CFG_W  = 11;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [1:0]               mode_t;
	typedef logic [1:0]               acc_op_t;

	localparam logic [CFG_W-1:0] LEAF_COUNT_RESET = 11'd1024;

	// Operation codes of an input word.
	localparam mode_t MODE_LOAD   = 2'd0;
	localparam mode_t MODE_BUILD  = 2'd1;
	localparam mode_t MODE_MODIFY = 2'd2;
	localparam mode_t MODE_QUERY  = 2'd3;

	// Accumulator operations.
	localparam acc_op_t ACC_HOLD  = 2'd0;
	localparam acc_op_t ACC_CLEAR = 2'd1;
	localparam acc_op_t ACC_LOAD  = 2'd2;
	localparam acc_op_t ACC_ADD   = 2'd3;

	typedef struct packed {
		acc_op_t op;
		logic    sel_value;
	} acc_ctl_t;

endpackage

FILE: rtl/bust_acc.sv
// Shared adder and accumulator of the segment tree block.
// Depends on bust_pkg.
module bust_acc (
	input  logic             clk,
	input  bust_pkg::acc_ctl_t ctl,
	input  bust_pkg::word_t  rdata,
	input  bust_pkg::word_t  value,
	output bust_pkg::word_t  acc,
	output bust_pkg::word_t  sum
);
	import bust_pkg::*;

	word_t acc_q;
	word_t operand;

	// The one adder of the block; sums wrap modulo 2^32.
	assign operand = ctl.sel_value ? value : rdata;
	assign sum     = acc_q + operand;
	assign acc     = acc_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			ACC_CLEAR: acc_q <= '0;
			ACC_LOAD:  acc_q <= operand;
			ACC_ADD:   acc_q <= sum;
			default:   acc_q <= acc_q;
		endcase
	end

endmodule

FILE: rtl/bust_ctrl.sv
// Sequencer and tree store of the segment tree block.
// Depends on bust_pkg and bust_acc.
module bust_ctrl #(
	parameter int LEAVES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  bust_pkg::mode_t            mode,
	input  logic [bust_pkg::POS_W-1:0] position,
	input  logic [bust_pkg::END_W-1:0] range_end,
	input  bust_pkg::word_t            value,
	input  logic [$clog2(LEAVES+1)-1:0] n,
	output logic                       busy,
	output logic                       done,
	output bust_pkg::word_t            range_sum
);
	import bust_pkg::*;

	localparam int DEPTH = 2 * LEAVES;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = AW + 1;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_LD   = 4'd2;
	localparam logic [3:0] S_B0   = 4'd3;
	localparam logic [3:0] S_B1   = 4'd4;
	localparam logic [3:0] S_BW   = 4'd5;
	localparam logic [3:0] S_MW   = 4'd6;
	localparam logic [3:0] S_MR   = 4'd7;
	localparam logic [3:0] S_MU   = 4'd8;
	localparam logic [3:0] S_QC   = 4'd9;
	localparam logic [3:0] S_QR   = 4'd10;
	localparam logic [3:0] S_QD   = 4'd11;

	logic [3:0]    state_q, state_d;
	logic [IW-1:0] l_q, l_d;
	logic [IW-1:0] r_q, r_d;
	logic          pend_q, pend_d;
	logic          done_q, done_d;
	word_t         val_q, val_d;
	word_t         range_sum_q, range_sum_d;

	word_t         mem [DEPTH];
	word_t         rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	word_t         mem_wdata;

	acc_ctl_t      acc_ctl;
	word_t         acc;
	word_t         sum;

	logic [IW-1:0] n_w, pos_w, end_w, end_c, r_dec;

	assign n_w   = IW'(n);
	assign pos_w = IW'(position);
	assign end_w = IW'(range_end);
	assign end_c = (end_w > n_w) ? n_w : end_w;
	assign r_dec = r_q - IW'(1);

	bust_acc u_acc (
		.clk   (clk),
		.ctl   (acc_ctl),
		.rdata (rdata_q),
		.value (val_q),
		.acc   (acc),
		.sum   (sum)
	);

	// Tree store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[mem_raddr];
	end

	always_comb begin
		state_d       = state_q;
		l_d           = l_q;
		r_d           = r_q;
		val_d         = val_q;
		pend_d        = 1'b0;
		done_d        = 1'b0;
		range_sum_d   = range_sum_q;
		mem_we        = 1'b0;
		mem_waddr     = l_q[AW-1:0];
		mem_wdata     = sum;
		mem_raddr     = l_q[AW-1:0];
		acc_ctl.op        = ACC_HOLD;
		acc_ctl.sel_value = 1'b0;
		case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
				l_d       = l_q + IW'(1);
				if (l_q == IW'(DEPTH - 1)) begin
					l_d     = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					case (mode)
						MODE_LOAD: begin
							if (pos_w < n_w) begin
								l_d     = pos_w + n_w;
								val_d   = value;
								state_d = S_LD;
							end
						end
						MODE_BUILD: begin
							if (n_w > IW'(1)) begin
								l_d     = n_w - IW'(1);
								state_d = S_B0;
							end
						end
						MODE_MODIFY: begin
							if (pos_w < n_w) begin
								l_d     = pos_w + n_w;
								val_d   = value;
								state_d = S_MW;
							end
						end
						default: begin
							acc_ctl.op = ACC_CLEAR;
							// An empty range walks no level and reports zero.
							if (pos_w < end_c) begin
								l_d = pos_w + n_w;
								r_d = end_c + n_w;
							end else begin
								l_d = '0;
								r_d = '0;
							end
							state_d = S_QC;
						end
					endcase
				end
			end
			S_LD: begin
				mem_we    = 1'b1;
				mem_wdata = val_q;
				state_d   = S_IDLE;
			end
			S_B0: begin
				mem_raddr  = {l_q[AW-2:0], 1'b0};
				acc_ctl.op = ACC_CLEAR;
				state_d    = S_B1;
			end
			S_B1: begin
				mem_raddr  = {l_q[AW-2:0], 1'b1};
				acc_ctl.op = ACC_ADD;
				state_d    = S_BW;
			end
			S_BW: begin
				mem_we = 1'b1;
				l_d    = l_q - IW'(1);
				if (l_q == IW'(1)) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_B0;
				end
			end
			S_MW: begin
				mem_we            = 1'b1;
				mem_wdata         = val_q;
				acc_ctl.op        = ACC_LOAD;
				acc_ctl.sel_value = 1'b1;
				if (l_q > IW'(1)) begin
					state_d = S_MR;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_MR: begin
				mem_raddr = l_q[AW-1:0] ^ AW'(1);
				state_d   = S_MU;
			end
			S_MU: begin
				mem_we     = 1'b1;
				mem_waddr  = l_q[AW:1];
				acc_ctl.op = ACC_ADD;
				l_d        = l_q >> 1;
				if ((l_q >> 1) > IW'(1)) begin
					state_d = S_MR;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_QC: begin
				if (pend_q) begin
					acc_ctl.op = ACC_ADD;
				end
				if (l_q < r_q) begin
					if (l_q[0]) begin
						l_d    = l_q + IW'(1);
						pend_d = 1'b1;
					end
					state_d = S_QR;
				end else begin
					state_d = S_QD;
				end
			end
			S_QR: begin
				if (pend_q) begin
					acc_ctl.op = ACC_ADD;
				end
				mem_raddr = r_dec[AW-1:0];
				if (r_q[0]) begin
					pend_d = 1'b1;
					r_d    = r_dec >> 1;
				end else begin
					r_d    = r_q >> 1;
				end
				l_d     = l_q >> 1;
				state_d = S_QC;
			end
			S_QD: begin
				done_d      = 1'b1;
				range_sum_d = acc;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			l_q     <= '0;
			r_q     <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			l_q     <= l_d;
			r_q     <= r_d;
			pend_q  <= pend_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q       <= val_d;
		range_sum_q <= range_sum_d;
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign range_sum = range_sum_q;

endmodule

FILE: rtl/bottom_up_segment_tree_sum.sv
// Range-sum segment tree over up to LEAVES signed 32-bit leaves. Raise start
// for one cycle while busy is low to hand in a word; busy then stays high
// until the block can take the next one. After reset the tree store is
// swept to zero, one entry a cycle, and busy stays high until the sweep has
// ended. A load writes the leaf. A modify writes the leaf, then for each
// level reads the sibling and writes the sum into the parent. A query walks
// the levels from the leaves up and adds in the boundary nodes. A build reads
// both children of each inner node, from n - 1 down to 1, and writes their sum.
// The steps are serial because of the single read port of the tree store and
// the one shared adder. A query result is put on range_sum with done high for
// exactly one cycle, the cycle in which busy falls; the receiver cannot stall
// it and must take it then. leaf_count must be written by the user through
// cfg_we/cfg_data only while the block is idle; the block does not enforce it.
//
// Top level of the segment tree block.
// Depends on bust_pkg, bust_ctrl and the assertion macro header.
`include "bottom_up_segment_tree_sum_macros.svh"

module bottom_up_segment_tree_sum #(
	parameter int LEAVES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  bust_pkg::mode_t            mode,
	input  logic [bust_pkg::POS_W-1:0] position,
	input  logic [bust_pkg::END_W-1:0] range_end,
	input  bust_pkg::word_t            value,
	output logic                       done,
	output bust_pkg::word_t            range_sum,
	input  logic                       cfg_we,
	input  logic [bust_pkg::CFG_W-1:0] cfg_data
);
	import bust_pkg::*;

	localparam int NW = $clog2(LEAVES + 1);

	logic [CFG_W-1:0] leaf_count_q;
	logic [NW-1:0]    n;
	logic             upd_accept;

	// The leaf count register; reset gives the full default tree.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_count_q <= LEAF_COUNT_RESET;
		end else if (cfg_we) begin
			leaf_count_q <= cfg_data;
		end
	end

	// The tree in use never grows past the store: the count saturates at
	// LEAVES. A count of zero gives an empty tree in which every update is
	// dropped and every query returns zero.
	assign n = (32'(leaf_count_q) > 32'(LEAVES)) ? NW'(LEAVES) : NW'(leaf_count_q);

	// The sequencer walks the tree level by level. Leaves sit at n + i and
	// inner node k holds the sum of nodes 2k and 2k + 1.
	bust_ctrl #(
		.LEAVES (LEAVES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.position  (position),
		.range_end (range_end),
		.value     (value),
		.n         (n),
		.busy      (busy),
		.done      (done),
		.range_sum (range_sum)
	);

	// A load, build or modify word taken in this cycle.
	assign upd_accept = start && !busy && (mode != MODE_QUERY);

	// A result word only appears once the walk has ended.
	`BUST_NEVER(a_done_while_busy, done && busy, "result word shown while busy")
	// Every result word lasts exactly one cycle.
	`BUST_ASSERT(a_done_pulse, done |=> !done, "result strobe held for two cycles")
	// Loads, builds and modifies never produce a result word.
	`BUST_ASSERT(a_no_result_update, upd_accept |=> !done, "result word after an update")

endmodule
